// ===== src/krt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants of the keyed record table
// Holds the operation codes, status codes, field widths and the sequencer
// state type.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int KEY_W   = 32;
   localparam int MARK_W  = 10;
   localparam int IDX_W   = 6;
   localparam int COUNT_W = 7;
   localparam int STAT_W  = 3;
   localparam int KIND_W  = 3;

   localparam int DEF_ENTRIES = 64;
   localparam logic [MARK_W-1:0] MARK_RESET = 10'd600;

   typedef enum logic [KIND_W-1:0] {
      OP_CLEAR  = 3'd0,
      OP_APPEND = 3'd1,
      OP_SEARCH = 3'd2,
      OP_UPDATE = 3'd3,
      OP_DELETE = 3'd4,
      OP_SORT   = 3'd5,
      OP_READ   = 3'd6,
      OP_NONE   = 3'd7
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_NOTFOUND = 3'd1,
      ST_FULL     = 3'd2,
      ST_BADMARK  = 3'd3,
      ST_RANGE    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DEL_RD,
      S_DEL_WR,
      S_SORT_RDI,
      S_SORT_RDJ,
      S_SORT_RDJ2,
      S_SORT_CMP,
      S_SORT_WB,
      S_READ_WAIT,
      S_DONE
   } state_type;

endpackage : krt_pkg
`default_nettype wire

// ===== src/krt_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// krt_mem: record storage
// Single-port synchronous memory of key and mark pairs with a registered read.
// ----------------------------------------------------------------------------
module krt_mem
   import krt_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES,
   localparam int AW = $clog2(ENTRIES)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     addr,
   input  wire logic [KEY_W-1:0]  wr_key,
   input  wire logic [MARK_W-1:0] wr_mark,
   output logic      [KEY_W-1:0]  rd_key,
   output logic      [MARK_W-1:0] rd_mark
);

   logic [KEY_W+MARK_W-1:0] mem [ENTRIES];

   // Write-first is not needed: the sequencer never uses the data read in a write cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= {wr_key, wr_mark};
      end
      {rd_key, rd_mark} <= mem[addr];
   end

endmodule : krt_mem
`default_nettype wire

// ===== src/keyed_record_table.sv =====
`default_nettype none
// Clear, append and unused kinds complete in the idle step; read passes through a wait and a check step.
// Search, update and delete walk the table one live entry at a time, and
// delete then shifts each following entry down by one place.
// Sort runs an exchange sort through one memory port.
// One item at a time; the result register is freed when rsp transfers.
// Synchronous reset clears the count and sets max_mark to 600; no clear pass.
// ----------------------------------------------------------------------------
// keyed_record_table: table of key and mark records
// Sequencer around one single-port record memory with a live entry count.
// ----------------------------------------------------------------------------
module keyed_record_table
   import krt_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [9:0]   csr_wr_data,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // kind[2:0], key[34:3], new_key[66:35], mark[76:67], index[82:77], zero pad
   input  wire logic [87:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[2:0], position[8:3], key_out[40:9], mark_out[50:41],
   // count[57:51], zero pad
   output logic [63:0]       rsp_tdata
);

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);

   state_type state_ff, state_in;
   logic [MARK_W-1:0] max_mark_ff;
   logic [CW-1:0] count_ff, count_in;
   op_type kind_ff, kind_in;
   logic [KEY_W-1:0] key_ff, key_in, nkey_ff, nkey_in;
   logic [MARK_W-1:0] mark_ff, mark_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [KEY_W-1:0] ki_ff, ki_in;
   logic [MARK_W-1:0] mi_ff, mi_in;
   logic [STAT_W-1:0] r_st_ff, r_st_in;
   logic [IDX_W-1:0] r_pos_ff, r_pos_in;
   logic [KEY_W-1:0] r_key_ff, r_key_in;
   logic [MARK_W-1:0] r_mark_ff, r_mark_in;
   logic rv_ff, rv_in;

   logic wr_en;
   logic [AW-1:0] addr;
   logic [KEY_W-1:0] wr_key, rd_key;
   logic [MARK_W-1:0] wr_mark, rd_mark;

   krt_mem #(.ENTRIES(ENTRIES)) u_mem (
      .clock, .wr_en, .addr, .wr_key, .wr_mark, .rd_key, .rd_mark
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         rv_ff       <= 1'b0;
         max_mark_ff <= MARK_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         if (csr_wr_en) begin
            max_mark_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;  key_ff   <= key_in;  nkey_ff <= nkey_in;
      mark_ff  <= mark_in;
      i_ff     <= i_in;     j_ff     <= j_in;
      ki_ff    <= ki_in;    mi_ff    <= mi_in;
      r_st_ff  <= r_st_in;  r_pos_ff <= r_pos_in;
      r_key_ff <= r_key_in; r_mark_ff <= r_mark_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {6'd0, COUNT_W'(count_ff), r_mark_ff, r_key_ff, r_pos_ff, r_st_ff};

   // Sequencer: next state, memory access and result.
   always_comb begin
      state_in = state_ff; count_in = count_ff;
      kind_in = kind_ff; key_in = key_ff; nkey_in = nkey_ff;
      mark_in = mark_ff;
      i_in = i_ff; j_in = j_ff; ki_in = ki_ff; mi_in = mi_ff;
      r_st_in = r_st_ff; r_pos_in = r_pos_ff;
      r_key_in = r_key_ff; r_mark_in = r_mark_ff;
      rv_in = rv_ff && !rsp_tready;
      wr_en = 1'b0; addr = i_ff[AW-1:0];
      wr_key = key_ff; wr_mark = mark_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               kind_in  = op_type'(req_tdata[2:0]);
               key_in   = req_tdata[34:3];
               nkey_in  = req_tdata[66:35];
               mark_in  = req_tdata[76:67];
               i_in = '0;
               state_in = S_DONE;
               r_st_in = ST_OK; r_pos_in = '0; r_key_in = '0; r_mark_in = '0;
               case (op_type'(req_tdata[2:0]))
                  OP_CLEAR: count_in = '0;
                  OP_APPEND: begin
                     if (count_ff >= FULL) begin
                        r_st_in = ST_FULL;
                     end else if (req_tdata[76:67] > max_mark_ff) begin
                        r_st_in = ST_BADMARK;
                     end else begin
                        wr_en = 1'b1; addr = count_ff[AW-1:0];
                        wr_key = req_tdata[34:3]; wr_mark = req_tdata[76:67];
                        r_pos_in = IDX_W'(count_ff);
                        r_key_in = req_tdata[34:3]; r_mark_in = req_tdata[76:67];
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_SEARCH, OP_UPDATE, OP_DELETE: state_in = S_SCAN_RD;
                  OP_SORT: state_in = S_SORT_RDI;
                  OP_READ: begin
                     if (CW'(req_tdata[82:77]) >= count_ff) begin
                        r_st_in = ST_RANGE;
                     end else begin
                        i_in = CW'(req_tdata[82:77]);
                        state_in = S_READ_WAIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ_WAIT: begin
            // Address is held in i_ff; data arrives next cycle.
            state_in = S_SCAN_CHK;
            kind_in = OP_READ;
         end
         S_SCAN_RD: begin
            if (i_ff >= count_ff) begin
               r_st_in = ST_NOTFOUND;
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (kind_ff == OP_READ) begin
               r_pos_in = IDX_W'(i_ff); r_key_in = rd_key; r_mark_in = rd_mark;
               state_in = S_DONE;
            end else if (rd_key != key_ff) begin
               i_in = i_ff + 1'b1;
               state_in = S_SCAN_RD;
            end else begin
               r_pos_in = IDX_W'(i_ff);
               state_in = S_DONE;
               case (kind_ff)
                  OP_SEARCH: begin
                     r_key_in = rd_key; r_mark_in = rd_mark;
                  end
                  OP_UPDATE: begin
                     if (mark_ff > max_mark_ff) begin
                        r_st_in = ST_BADMARK; r_pos_in = '0;
                     end else begin
                        wr_en = 1'b1; wr_key = nkey_ff;
                        r_key_in = nkey_ff; r_mark_in = mark_ff;
                     end
                  end
                  default: begin
                     r_key_in = rd_key; r_mark_in = rd_mark;
                     j_in = i_ff;
                     state_in = S_DEL_RD;
                  end
               endcase
            end
         end
         S_DEL_RD: begin
            // Read entry j+1 to move it into j.
            if (j_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               addr = AW'(j_ff + 1'b1);
               state_in = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            wr_en = 1'b1; addr = j_ff[AW-1:0];
            wr_key = rd_key; wr_mark = rd_mark;
            j_in = j_ff + 1'b1;
            state_in = S_DEL_RD;
         end
         S_SORT_RDI: begin
            if (i_ff + 1'b1 >= count_ff || count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               j_in = i_ff + 1'b1;
               state_in = S_SORT_RDJ;
            end
         end
         S_SORT_RDJ: begin
            // Entry i data lands now, read during the RDI step.
            if (j_ff == i_ff + 1'b1) begin
               ki_in = rd_key; mi_in = rd_mark;
            end
            addr = j_ff[AW-1:0];
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            if (ki_ff > rd_key) begin
               wr_en = 1'b1; addr = j_ff[AW-1:0];
               wr_key = ki_ff; wr_mark = mi_ff;
               ki_in = rd_key; mi_in = rd_mark;
            end
            if (j_ff + 1'b1 >= count_ff) begin
               state_in = S_SORT_WB;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = S_SORT_RDJ2;
            end
         end
         S_SORT_RDJ2: begin
            addr = j_ff[AW-1:0];
            state_in = S_SORT_CMP;
         end
         S_SORT_WB: begin
            // Settled minimum goes back to position i.
            wr_en = 1'b1; addr = i_ff[AW-1:0];
            wr_key = ki_ff; wr_mark = mi_ff;
            i_in = i_ff + 1'b1;
            state_in = S_SORT_RDI;
         end
         S_DONE: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef NO_ASSERTIONS
   // The live count never exceeds the table depth.
   a_count: assert property (@(posedge clock) disable iff (reset) count_ff <= FULL)
      else $error("entry count beyond depth");
   // No item is taken while a result is pending.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req_tready)
      else $error("input accepted with result pending");
   // A result comes only from the done step.
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside done step");
`endif

endmodule : keyed_record_table
`default_nettype wire

// ===== bench/tb_keyed_record_table.sv =====
// ----------------------------------------------------------------------------
// tb_keyed_record_table: self-checking bench for the keyed record table
// Drives table operations through the request stream, predicts every
// response with a behavioral copy of the table, and compares field by field.
// ----------------------------------------------------------------------------
module tb_keyed_record_table
   import krt_pkg::*;
();

   localparam int N_ENTRIES = 64;
   localparam int CYCLE_LIMIT = 20000000;

   typedef struct packed {
      logic [6:0]  count;
      logic [9:0]  mark_out;
      logic [31:0] key_out;
      logic [5:0]  position;
      logic [2:0]  status;
   } rsp_item;

   typedef struct {
      op_type      kind;
      logic [31:0] key;
      logic [31:0] new_key;
      logic [9:0]  mark;
      logic [5:0]  index;
      logic        typed;
      logic [2:0]  st;
      logic [6:0]  cnt;
   } dir_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [9:0]  csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   // Behavioral copy of the table.
   logic [31:0] tbl_key [N_ENTRIES];
   logic [9:0]  tbl_mark [N_ENTRIES];
   int          tbl_count;
   logic [9:0]  mark_limit;

   rsp_item     pending_rsp [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          hold_off = 1'b0;
   bit          calm = 1'b0;

   keyed_record_table dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Cycle limit watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_keyed_record_table NOT OK");
         $finish;
      end
   end

   function automatic rsp_item make_rsp(int st, int pos, logic [31:0] k, logic [9:0] m);
      rsp_item r;
      r.status = st[2:0];
      r.position = pos[5:0];
      r.key_out = k;
      r.mark_out = m;
      r.count = tbl_count[6:0];
      return r;
   endfunction

   function automatic int find_key(logic [31:0] k);
      for (int p = 0; p < tbl_count; p++)
         if (tbl_key[p] == k) return p;
      return -1;
   endfunction

   // Applies one operation to the table copy and returns the predicted response.
   function automatic rsp_item apply_table_op(op_type kind, logic [31:0] k,
                                              logic [31:0] nk, logic [9:0] m,
                                              logic [5:0] idx);
      int p;
      logic [31:0] tk;
      logic [9:0]  tm;
      case (kind)
         OP_CLEAR: begin
            tbl_count = 0;
            return make_rsp(ST_OK, 0, 0, 0);
         end
         OP_APPEND: begin
            if (tbl_count >= N_ENTRIES) return make_rsp(ST_FULL, 0, 0, 0);
            if (m > mark_limit) return make_rsp(ST_BADMARK, 0, 0, 0);
            tbl_key[tbl_count] = k;
            tbl_mark[tbl_count] = m;
            tbl_count++;
            return make_rsp(ST_OK, tbl_count - 1, k, m);
         end
         OP_SEARCH: begin
            p = find_key(k);
            if (p < 0) return make_rsp(ST_NOTFOUND, 0, 0, 0);
            return make_rsp(ST_OK, p, tbl_key[p], tbl_mark[p]);
         end
         OP_UPDATE: begin
            p = find_key(k);
            if (p < 0) return make_rsp(ST_NOTFOUND, 0, 0, 0);
            if (m > mark_limit) return make_rsp(ST_BADMARK, 0, 0, 0);
            tbl_key[p] = nk;
            tbl_mark[p] = m;
            return make_rsp(ST_OK, p, nk, m);
         end
         OP_DELETE: begin
            p = find_key(k);
            if (p < 0) return make_rsp(ST_NOTFOUND, 0, 0, 0);
            tk = tbl_key[p];
            tm = tbl_mark[p];
            for (int q = p; q + 1 < tbl_count; q++) begin
               tbl_key[q] = tbl_key[q + 1];
               tbl_mark[q] = tbl_mark[q + 1];
            end
            tbl_count--;
            return make_rsp(ST_OK, p, tk, tm);
         end
         OP_SORT: begin
            for (int i = 0; i < tbl_count; i++)
               for (int j = i + 1; j < tbl_count; j++)
                  if (tbl_key[i] > tbl_key[j]) begin
                     tk = tbl_key[i]; tbl_key[i] = tbl_key[j]; tbl_key[j] = tk;
                     tm = tbl_mark[i]; tbl_mark[i] = tbl_mark[j]; tbl_mark[j] = tm;
                  end
            return make_rsp(ST_OK, 0, 0, 0);
         end
         OP_READ: begin
            if (idx >= tbl_count) return make_rsp(ST_RANGE, 0, 0, 0);
            return make_rsp(ST_OK, idx, tbl_key[idx], tbl_mark[idx]);
         end
         default: return make_rsp(ST_OK, 0, 0, 0);
      endcase
   endfunction

   // Offers one request and waits for its transfer.
   task automatic send_op(op_type kind, logic [31:0] k, logic [31:0] nk,
                          logic [9:0] m, logic [5:0] idx, bit typed,
                          logic [2:0] st, logic [6:0] cnt);
      rsp_item r;
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {5'd0, idx, m, nk, k, kind};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = apply_table_op(kind, k, nk, m, idx);
      if (typed && (r.status != st || r.count != cnt)) begin
         $display("%0t: table copy disagrees with typed row: exp %0d/%0d got %0d/%0d",
                  $time, st, cnt, r.status, r.count);
         fail_count++;
      end
      pending_rsp.push_back(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_limit(logic [9:0] v);
      drain();
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mark_limit = v;
   endtask

   // Response checker and receiver stalls.
   always @(posedge clock) begin
      rsp_item got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[57:0];
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.status != want.status)
               $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            if (got.position != want.position)
               $display("%0t: position exp %0d got %0d", $time, want.position, got.position);
            if (got.key_out != want.key_out)
               $display("%0t: key_out exp %h got %h", $time, want.key_out, got.key_out);
            if (got.mark_out != want.mark_out)
               $display("%0t: mark_out exp %0d got %0d", $time, want.mark_out, got.mark_out);
            if (got.count != want.count)
               $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
            if (got != want) fail_count++;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !hold_off && (calm || $urandom_range(99) >= 31);
   end

   // Long receiver hold-off while the sender keeps offering.
   initial begin
      wait (cycle_count == 6000);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   dir_row rows [$];

   function automatic logic [31:0] pick_key();
      if (tbl_count != 0 && $urandom_range(99) < 70)
         return tbl_key[$urandom_range(tbl_count - 1)];
      return ($urandom_range(1) != 0) ? $urandom() : 32'($urandom_range(15));
   endfunction

   function automatic logic [9:0] pick_mark();
      if ($urandom_range(9) == 0) return 10'($urandom());
      return 10'($urandom_range(mark_limit));
   endfunction

   initial begin
      int kind_sel;
      op_type kind;
      mark_limit = MARK_RESET;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed rows; status and count are typed only where obvious.
      rows.push_back('{OP_READ,   0, 0, 0, 0, 1, ST_RANGE, 0});
      rows.push_back('{OP_SEARCH, 5, 0, 0, 0, 1, ST_NOTFOUND, 0});
      rows.push_back('{OP_DELETE, 5, 0, 0, 0, 1, ST_NOTFOUND, 0});
      rows.push_back('{OP_UPDATE, 5, 1, 1, 0, 1, ST_NOTFOUND, 0});
      rows.push_back('{OP_APPEND, 32'hFFFFFFFF, 0, 600, 0, 1, ST_OK, 1});
      rows.push_back('{OP_APPEND, 0, 0, 601, 0, 1, ST_BADMARK, 1});
      rows.push_back('{OP_APPEND, 0, 0, 0, 0, 1, ST_OK, 2});
      rows.push_back('{OP_APPEND, 7, 0, 5, 0, 0, 0, 0});
      rows.push_back('{OP_APPEND, 7, 0, 9, 0, 0, 0, 0});
      rows.push_back('{OP_SEARCH, 7, 0, 0, 0, 0, 0, 0});
      rows.push_back('{OP_UPDATE, 7, 3, 1023, 0, 1, ST_BADMARK, 4});
      rows.push_back('{OP_UPDATE, 7, 32'hFFFFFFFF, 1, 0, 0, 0, 0});
      rows.push_back('{OP_SORT,   0, 0, 0, 0, 1, ST_OK, 4});
      rows.push_back('{OP_READ,   0, 0, 0, 0, 0, 0, 0});
      rows.push_back('{OP_READ,   0, 0, 0, 3, 0, 0, 0});
      rows.push_back('{OP_READ,   0, 0, 0, 63, 1, ST_RANGE, 4});
      rows.push_back('{OP_DELETE, 0, 0, 0, 0, 0, 0, 0});
      rows.push_back('{OP_DELETE, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0});
      rows.push_back('{OP_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1023, 63, 1, ST_OK, 2});
      rows.push_back('{OP_CLEAR,  0, 0, 0, 0, 1, ST_OK, 0});
      foreach (rows[i])
         send_op(rows[i].kind, rows[i].key, rows[i].new_key, rows[i].mark,
                 rows[i].index, rows[i].typed, rows[i].st, rows[i].cnt);

      // Fill to capacity with accepted marks, then overflow.
      for (int i = 0; i < N_ENTRIES; i++)
         send_op(OP_APPEND, $urandom(), 0, 10'($urandom_range(mark_limit)), 0, 0, 0, 0);
      send_op(OP_APPEND, 1, 0, 1023, 0, 1, ST_FULL, 64);
      send_op(OP_READ, 0, 0, 0, 63, 0, 0, 0);
      send_op(OP_SORT, 0, 0, 0, 0, 1, ST_OK, 64);
      send_op(OP_DELETE, pick_key(), 0, 0, 0, 0, 0, 0);

      // Random phases under several mark limits.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_limit(10'd1023);
            1: write_limit(10'd1);
            2: write_limit(10'($urandom_range(1, 1023)));
            3: write_limit(10'd512);
            default: write_limit(10'd1023);
         endcase
         calm = (ph == 3);
         for (int i = 0; i < 90; i++) begin
            kind_sel = $urandom_range(99);
            if (kind_sel < 30) kind = OP_APPEND;
            else if (kind_sel < 45) kind = OP_SEARCH;
            else if (kind_sel < 58) kind = OP_UPDATE;
            else if (kind_sel < 72) kind = OP_DELETE;
            else if (kind_sel < 88) kind = OP_READ;
            else if (kind_sel < 91) kind = OP_SORT;
            else if (kind_sel < 94) kind = OP_CLEAR;
            else kind = OP_NONE;
            send_op(kind, pick_key(), $urandom(), pick_mark(),
                    ($urandom_range(3) == 0) ? 6'($urandom()) :
                    6'($urandom_range(tbl_count == 0 ? 0 : tbl_count - 1)), 0, 0, 0);
         end
      end
      calm = 1'b0;

      drain();
      if (fail_count == 0)
         $display("tb_keyed_record_table OK");
      else
         $display("tb_keyed_record_table NOT OK");
      $finish;
   end
endmodule
